// ===== hdl/rrpc_pkg.sv =====
// Shared constants, widths and the item type that moves along the region cell chain.
package rrpc_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int PAGE_BITS   = 12;

    localparam int ADDR_W  = 64;
    localparam int PAGE_W  = 52;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;

    // A rounded-up start page needs one bit more than the shifted address.
    localparam int LO_W  = ADDR_W - PAGE_BITS + 1;
    localparam int CMP_W = (LO_W > PAGE_W + 1) ? LO_W : PAGE_W + 1;

    localparam int CELL_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int ID_W   = (CELL_W > INDEX_W) ? CELL_W : INDEX_W;
    localparam int CNT_W  = (CELL_W > COUNT_W) ? CELL_W : COUNT_W;

    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 56;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               valid;
        logic               query;
        logic [INDEX_W-1:0] index;
        logic               usable;
        logic [CMP_W-1:0]   lo;
        logic [CMP_W-1:0]   hi;
        logic [CMP_W-1:0]   page;
        logic [CMP_W-1:0]   succ;
        logic               ram;
        logic               succ_ram;
        logic               have_best;
        logic [CMP_W-1:0]   best;
    } item_t;

endpackage

// ===== hdl/rrpc_prep.sv =====
// Input stage: unpacks a beat and works out page bounds or the successor page.
module rrpc_prep (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic                            s_tvalid,
    input  logic [rrpc_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output rrpc_pkg::item_t                 item_out
);
    import rrpc_pkg::*;

    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  length;
    logic [ADDR_W-1:0]  end_addr;
    logic [PAGE_W-1:0]  page;
    logic [CMP_W-1:0]   page_ext;
    item_t              item_next;
    item_t              item_reg;

    assign base     = s_tdata[68:5];
    assign length   = s_tdata[132:69];
    assign page     = s_tdata[185:134];
    assign end_addr = base + length;
    assign page_ext = CMP_W'(page);

    always_comb begin
        item_next           = '0;
        item_next.valid     = s_tvalid;
        item_next.query     = (s_tuser == OP_QUERY);
        item_next.index     = s_tdata[4:0];
        item_next.usable    = s_tdata[133];
        // The start rounds up to the next page boundary without wrapping.
        item_next.lo        = CMP_W'(base[ADDR_W-1:PAGE_BITS])
                            + CMP_W'(|base[PAGE_BITS-1:0]);
        item_next.hi        = CMP_W'(end_addr[ADDR_W-1:PAGE_BITS]);
        item_next.page      = page_ext;
        item_next.succ      = page_ext + CMP_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (advance) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ===== hdl/rrpc_cell.sv =====
// One region slot: holds its page bounds and folds its answer into each passing query.
module rrpc_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic [rrpc_pkg::CELL_W-1:0]     cell_id,
    input  logic [rrpc_pkg::COUNT_W-1:0]    region_count,
    input  rrpc_pkg::item_t                 item_in,
    output rrpc_pkg::item_t                 item_out
);
    import rrpc_pkg::*;

    logic [CMP_W-1:0] lo_reg;
    logic [CMP_W-1:0] hi_reg;
    logic             usable_reg;
    logic             active;
    logic             hit;
    logic             wr;
    item_t            item_next;
    item_t            item_reg;

    assign active = CNT_W'(cell_id) < CNT_W'(region_count);
    assign hit    = item_in.valid && item_in.query && active && usable_reg;
    assign wr     = item_in.valid && !item_in.query
                  && (ID_W'(item_in.index) == ID_W'(cell_id));

    always_comb begin
        item_next = item_in;
        if (hit) begin
            if (item_in.page >= lo_reg && item_in.page < hi_reg) begin
                item_next.ram = 1'b1;
            end
            if (item_in.succ >= lo_reg && item_in.succ < hi_reg) begin
                item_next.succ_ram = 1'b1;
            end
            if (item_in.succ < lo_reg && (!item_in.have_best || lo_reg < item_in.best)) begin
                item_next.best      = lo_reg;
                item_next.have_best = 1'b1;
            end
        end
    end

    // A write lands here as it passes, so queries behind it see the new entry.
    always_ff @(posedge aclk) begin
        if (advance && wr) begin
            lo_reg     <= item_in.lo;
            hi_reg     <= item_in.hi;
            usable_reg <= item_in.usable;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (advance) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ===== hdl/ram_region_page_classifier.sv =====
// Top level of the region table page classifier: input stage, cell chain, result register.
//
// Beats on the s_ channel are either region writes (s_tuser low) or page
// queries (s_tuser high). Each beat enters an input stage and then walks a
// chain of one cell per region slot, one cell per chain advance. A write is stored
// by the cell whose slot it names; a query collects the in-RAM answer and
// the lowest usable start above the following page from every active cell.
// Queries return one beat on the m_ channel; writes return nothing.
// A query's result beat is offered once it has passed the input stage register,
// every cell register and the result register; one beat is accepted every
// cycle while the receiver does not stall.
// The region count is written on the cfg_ channel, which is always ready,
// and must only change while no beat is in flight.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_tready falls; nothing is lost or reordered.
// Reset clears the count to zero and empties the chain; table contents are
// undefined until written.
module ram_region_page_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[4:0], region_base[68:5], region_length[132:69],
    // region_usable[133], page_number[185:134], zero fill above
    input  logic [rrpc_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // is_ram[0], next_page[52:1], zero fill above
    output logic [rrpc_pkg::M_DATA_W-1:0]   m_tdata,
    // next_found[0]
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rrpc_pkg::COUNT_W-1:0]    cfg_data
);
    import rrpc_pkg::*;

    logic               advance;
    logic [COUNT_W-1:0] count_reg;
    item_t              chain [0:MAX_REGIONS];
    item_t              last;
    logic               found;
    logic               succ_hit;
    logic [CMP_W-1:0]   best;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_DATA_W-1:0] m_data_next;
    logic               m_found_reg;

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    rrpc_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .item_out (chain[0])
    );

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        rrpc_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .advance      (advance),
            .cell_id      (CELL_W'(i)),
            .region_count (count_reg),
            .item_in      (chain[i]),
            .item_out     (chain[i+1])
        );
    end

    assign last     = chain[MAX_REGIONS];
    assign succ_hit = last.succ_ram;
    assign best     = succ_hit ? last.succ : last.best;
    // The next page must also fit the 52-bit result field.
    assign found    = (succ_hit || last.have_best) && (best[CMP_W-1:PAGE_W] == '0);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = last.valid && last.query;
            m_data_next  = {(M_DATA_W-PAGE_W-1)'(0),
                            found ? best[PAGE_W-1:0] : PAGE_W'(0),
                            last.ram};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (advance) begin
            m_found_reg <= found;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[PAGE_W:1] == '0)
        else $error("next page not cleared when no RAM page follows");

    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[PAGE_W:1] != '0)
        else $error("found next page lies at page zero");

    a_chain_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(last.valid) && $stable(m_tdata))
        else $error("chain moved while the receiver stalled");

endmodule
